// ===== rtl/nso_pkg.sv =====
// Shared constants and elaboration-time table builders for the note sine oscillator.
`default_nettype none

package nso_pkg;

  localparam int unsigned SampleRateHzDefault = 48000;
  localparam int unsigned PhaseBitsDefault    = 32;
  localparam int unsigned TableBitsDefault    = 10;

  localparam int unsigned NoteWidth   = 7;
  localparam int unsigned NoteCount   = 1 << NoteWidth;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned MagWidth    = 15;

  localparam logic [NoteWidth-1:0] NoteReset = 7'd69;

  localparam logic [63:0] Q30One     = 64'd1073741824;
  localparam logic [63:0] RoundQ30   = 64'h0000_0000_2000_0000;
  localparam logic [63:0] HalfPiQ30  = 64'd1686629713;
  localparam logic [63:0] Ln2Q30     = 64'd744261118;
  localparam logic [63:0] RefFreqHz  = 64'd440;
  localparam logic [63:0] SinePeak   = 64'd32767;

  localparam logic [63:0] ExpDiv [14] = '{
    64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7,
    64'd8, 64'd9, 64'd10, 64'd11, 64'd12, 64'd13, 64'd14
  };

  localparam logic [63:0] SinDiv [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + RoundQ30) >> 30;
  endfunction

  function automatic logic [63:0] exp_q30(logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    logic [4:0]  k;
    sum  = Q30One;
    term = Q30One;
    for (k = 5'd0; k < 5'd14; k = k + 5'd1) begin
      term = mul_q30(term, z) / ExpDiv[k[3:0]];
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] sin_q30(logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [3:0]         k;
    x2   = mul_q30(x, x);
    term = x;
    sum  = signed'(x);
    for (k = 4'd0; k < 4'd8; k = k + 4'd1) begin
      term = mul_q30(term, x2) / SinDiv[k[2:0]];
      if (k[0] == 1'b0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return sum;
  endfunction

  // Quarter-wave magnitude for entry i of a table with 2^tb steps per quarter turn.
  function automatic logic [MagWidth-1:0] sine_entry(logic [63:0] i, logic [4:0] tb);
    logic [63:0]        half_len;
    logic [63:0]        x;
    logic signed [63:0] s;
    logic [63:0]        v;
    half_len = (64'd1 << tb) >> 1;
    x        = (HalfPiQ30 * i + half_len) >> tb;
    s        = sin_q30(x);
    if (s < 0) begin
      s = 64'sd0;
    end
    v = (unsigned'(s) * SinePeak + RoundQ30) >> 30;
    if (v > SinePeak) begin
      v = SinePeak;
    end
    return v[MagWidth-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nso_phase.sv =====
// Phase accumulator with the note increment table and increment register.
`default_nettype none

module nso_phase #(
  parameter int unsigned SAMPLE_RATE_HZ = nso_pkg::SampleRateHzDefault,
  parameter int unsigned PHASE_BITS     = nso_pkg::PhaseBitsDefault
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic                             tick,
  input  wire logic                             note_number_we,
  input  wire logic [nso_pkg::NoteWidth-1:0]    note_number,
  output logic      [PHASE_BITS-1:0]            phase
);

  localparam logic [63:0] SampleRate     = 64'(SAMPLE_RATE_HZ);
  localparam logic [63:0] SampleRateHalf = 64'(SAMPLE_RATE_HZ / 2);

  function automatic logic [PHASE_BITS-1:0] incr_entry(logic [7:0] n);
    logic [7:0]  m;
    logic [7:0]  oct;
    logic [7:0]  semi;
    logic [63:0] z;
    logic [63:0] num;
    logic [63:0] inc;
    int          e;
    m    = n + 8'd3;
    oct  = m / 8'd12;
    semi = m % 8'd12;
    z    = (64'(semi) * nso_pkg::Ln2Q30 + 64'd6) / 64'd12;
    num  = nso_pkg::RefFreqHz * nso_pkg::exp_q30(z);
    e    = int'(oct) - 36 + int'(PHASE_BITS);
    if (e >= 0) begin
      inc = ((num << e) + SampleRateHalf) / SampleRate;
    end else begin
      inc = ((num + ((SampleRate << (-e)) >> 1)) >> (-e)) / SampleRate;
    end
    return inc[PHASE_BITS-1:0];
  endfunction

  logic [PHASE_BITS-1:0] incr_table [nso_pkg::NoteCount];
  logic [PHASE_BITS-1:0] incr;
  logic [PHASE_BITS-1:0] phase_next;

  for (genvar g = 0; g < nso_pkg::NoteCount; g++) begin : g_incr
    assign incr_table[g] = incr_entry(8'(g));
  end

  assign phase_next = phase + incr;

  always_ff @(posedge clk) begin
    if (rst) begin
      incr  <= incr_table[nso_pkg::NoteReset];
      phase <= '0;
    end else begin
      if (note_number_we) begin
        incr <= incr_table[note_number];
      end
      if (accept && tick) begin
        phase <= phase_next;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && tick) |=> $stable(phase))
    else $error("phase moved without a tick transfer");
`endif

endmodule

`default_nettype wire

// ===== rtl/nso_sine.sv =====
// Quarter-wave sine lookup with registered ROM read and output register.
`default_nettype none

module nso_sine #(
  parameter int unsigned TABLE_BITS = nso_pkg::TableBitsDefault
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   load,
  input  wire logic        [TABLE_BITS+1:0]           phase_top,
  output logic                                        busy,
  output logic                                        sample_valid,
  input  wire logic                                   sample_stall,
  output logic signed      [nso_pkg::SampleWidth-1:0] sample
);

  localparam int unsigned QuarterLen = 1 << TABLE_BITS;
  localparam logic [TABLE_BITS:0] QuarterAddr = {1'b1, {TABLE_BITS{1'b0}}};

  logic [nso_pkg::MagWidth-1:0] rom [QuarterLen+1];
  logic [TABLE_BITS-1:0]        idx;
  logic [TABLE_BITS:0]          addr;
  logic                         s1_valid;
  logic [nso_pkg::MagWidth-1:0] mag;
  logic                         neg;
  logic                         en1;
  logic                         en2;

  for (genvar g = 0; g <= QuarterLen; g++) begin : g_rom
    assign rom[g] = nso_pkg::sine_entry(64'(g), 5'(TABLE_BITS));
  end

  assign idx  = phase_top[TABLE_BITS-1:0];
  assign addr = phase_top[TABLE_BITS] ? (QuarterAddr - {1'b0, idx}) : {1'b0, idx};

  assign en2  = !sample_valid || !sample_stall;
  assign en1  = !s1_valid || en2;
  assign busy = !en1;

  always_ff @(posedge clk) begin
    if (en1) begin
      mag <= rom[addr];
      neg <= phase_top[TABLE_BITS+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sample <= neg ? (16'sd0 - signed'({1'b0, mag})) : signed'({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= load;
      end
      if (en2) begin
        sample_valid <= s1_valid;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    sample_valid |-> (sample != 16'sh8000))
    else $error("sample reached the negative full-scale code");

  a_s1_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && en2) |=> sample_valid)
    else $error("lookup stage dropped a transfer");

  a_load_fill: assert property (@(posedge clk) disable iff (rst)
    (load && en1) |=> s1_valid)
    else $error("accepted tick did not reach the lookup stage");
`endif

endmodule

`default_nettype wire

// ===== rtl/note_sine_oscillator.sv =====
// Top level of the note-driven sine oscillator.
// Sine oscillator tuned by a MIDI note number (note 69 is 440 Hz, equal temperament).
// Each tick transfer yields one signed Q1.15 sample, the sine of the phase before the
// note's increment is added; a tick of zero still yields a sample and leaves the phase
// alone. A new tick is taken every cycle unless tick_stall is high; each sample passes
// through the registered quarter-wave ROM read and then the output register. A note
// write takes effect from the next tick and keeps the phase. There is no clearing pass:
// all tables are built at elaboration.
`default_nettype none

module note_sine_oscillator #(
  parameter int unsigned SAMPLE_RATE_HZ = nso_pkg::SampleRateHzDefault,
  parameter int unsigned PHASE_BITS     = nso_pkg::PhaseBitsDefault,
  parameter int unsigned TABLE_BITS     = nso_pkg::TableBitsDefault
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   tick_valid,
  output logic                                        tick_stall,
  input  wire logic                                   tick,
  output logic                                        sample_valid,
  input  wire logic                                   sample_stall,
  output logic signed      [nso_pkg::SampleWidth-1:0] sample,
  input  wire logic                                   note_number_we,
  input  wire logic        [nso_pkg::NoteWidth-1:0]   note_number
);

  logic                  accept;
  logic [PHASE_BITS-1:0] phase;

  assign accept = tick_valid && !tick_stall;

  nso_phase #(
    .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
    .PHASE_BITS     (PHASE_BITS)
  ) u_phase (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .tick           (tick),
    .note_number_we (note_number_we),
    .note_number    (note_number),
    .phase          (phase)
  );

  nso_sine #(
    .TABLE_BITS (TABLE_BITS)
  ) u_sine (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .phase_top    (phase[PHASE_BITS-1 -: TABLE_BITS+2]),
    .busy         (tick_stall),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample)
  );

endmodule

`default_nettype wire

// ===== verif/note_sine_oscillator_tb.sv =====
// Self-checking testbench for note_sine_oscillator: directed table, random note phases, predictor.
`timescale 1ns / 100ps

module note_sine_oscillator_tb;

  localparam int unsigned PhaseBits  = nso_pkg::PhaseBitsDefault;
  localparam int unsigned TableBits  = nso_pkg::TableBitsDefault;
  localparam int unsigned SampleRate = nso_pkg::SampleRateHzDefault;
  localparam int unsigned QuarterLen = 1 << TableBits;
  localparam int unsigned NoteW      = nso_pkg::NoteWidth;
  localparam int unsigned SampleW    = nso_pkg::SampleWidth;
  localparam int unsigned MagW       = nso_pkg::MagWidth;
  localparam int          StuckLimit = 2000;
  localparam int          PhaseCount = 12;
  localparam int          PhaseItems = 95;

  typedef struct packed {
    logic                      wr;
    logic [NoteW-1:0]          note;
    logic                      tick;
    logic                      pinned;
    logic signed [SampleW-1:0] val;
  } dir_step_t;

  localparam int DirCount = 20;
  localparam dir_step_t DirSteps [DirCount] = '{
    '{1'b0, 7'd0,   1'b0, 1'b1, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b1, 16'sd0},
    '{1'b0, 7'd0,   1'b0, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b0, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b1, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b0, 1'b0, 16'sd0},
    '{1'b1, 7'd127, 1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b0, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b1, 7'h55,  1'b1, 1'b0, 16'sd0},
    '{1'b1, 7'h2A,  1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b1, 7'd69,  1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0},
    '{1'b0, 7'd0,   1'b1, 1'b0, 16'sd0}
  };

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      tick_valid;
  logic                      tick_stall;
  logic                      tick;
  logic                      sample_valid;
  logic                      sample_stall = 1'b0;
  logic signed [SampleW-1:0] sample;
  logic                      note_number_we;
  logic [NoteW-1:0]          note_number;

  logic                      fixed_en;
  logic signed [SampleW-1:0] fixed_val;
  logic                      calm;

  logic [MagW-1:0]           sine_mag [0:QuarterLen];
  logic [PhaseBits-1:0]      note_step [nso_pkg::NoteCount];
  logic [PhaseBits-1:0]      phase_acc;
  logic [NoteW-1:0]          cur_note;
  logic signed [SampleW-1:0] expected_samples [$];

  int ticks_sent      = 0;
  int zero_ticks      = 0;
  int note_writes     = 0;
  int samples_checked = 0;
  int errors          = 0;
  int stuck_cycles    = 0;

  note_sine_oscillator dut (
    .clk            (clk),
    .rst            (rst),
    .tick_valid     (tick_valid),
    .tick_stall     (tick_stall),
    .tick           (tick),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .note_number_we (note_number_we),
    .note_number    (note_number)
  );

  always #10 clk = ~clk;

  function automatic longint unsigned q30_product(longint unsigned a, longint unsigned b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic longint unsigned exp_fixed(longint unsigned z);
    longint unsigned sum;
    longint unsigned term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int k = 1; k <= 14; k++) begin
      term = q30_product(term, z) / 64'(k);
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic longint sin_fixed(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = q30_product(x, x);
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = q30_product(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  function automatic void build_tables();
    longint unsigned x;
    longint unsigned v;
    longint unsigned z;
    longint unsigned num;
    longint unsigned inc;
    longint unsigned d;
    longint          s;
    int              oct;
    int              semi;
    int              e;
    for (int i = 0; i <= int'(QuarterLen); i++) begin
      x = (nso_pkg::HalfPiQ30 * 64'(i) + 64'(QuarterLen >> 1)) >> TableBits;
      s = sin_fixed(x);
      if (s < 0) begin
        s = 0;
      end
      v = ($unsigned(s) * nso_pkg::SinePeak + 64'd536870912) >> 30;
      if (v > nso_pkg::SinePeak) begin
        v = nso_pkg::SinePeak;
      end
      sine_mag[i] = v[MagW-1:0];
    end
    for (int n = 0; n < int'(nso_pkg::NoteCount); n++) begin
      oct  = (n + 3) / 12;
      semi = (n + 3) % 12;
      z    = (64'(semi) * nso_pkg::Ln2Q30 + 64'd6) / 64'd12;
      num  = nso_pkg::RefFreqHz * exp_fixed(z);
      e    = oct - 36 + int'(PhaseBits);
      if (e >= 0) begin
        inc = ((num << e) + 64'(SampleRate / 2)) / 64'(SampleRate);
      end else begin
        d   = 64'(SampleRate) << (-e);
        inc = (num + (d >> 1)) / d;
      end
      note_step[n] = inc[PhaseBits-1:0];
    end
  endfunction

  function automatic logic signed [SampleW-1:0] sine_at(logic [PhaseBits-1:0] ph);
    logic [TableBits+1:0] top;
    logic [1:0]           quad;
    logic [TableBits-1:0] idx;
    logic [TableBits:0]   addr;
    logic [MagW-1:0]      mag;
    top  = ph[PhaseBits-1 -: TableBits+2];
    quad = top[TableBits+1:TableBits];
    idx  = top[TableBits-1:0];
    addr = quad[0] ? ((TableBits+1)'(QuarterLen) - {1'b0, idx}) : {1'b0, idx};
    mag  = sine_mag[addr];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Predict on each tick transfer, check each sample transfer.
  always @(posedge clk) begin
    logic signed [SampleW-1:0] want;
    if (rst) begin
      phase_acc = '0;
      cur_note  = nso_pkg::NoteReset;
      expected_samples.delete();
    end else begin
      if (sample_valid && !sample_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, got %0d", $time, sample);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (sample !== want) begin
            $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, sample);
            errors++;
          end
        end
      end
      if (tick_valid && !tick_stall) begin
        expected_samples.push_back(fixed_en ? fixed_val : sine_at(phase_acc));
        if (tick) begin
          phase_acc = phase_acc + note_step[cur_note];
        end
      end
      if (note_number_we) begin
        cur_note = note_number;
      end
    end
  end

  always @(posedge clk) begin
    sample_stall <= !calm && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    if (rst || (tick_valid && !tick_stall) || (sample_valid && !sample_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StuckLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic t, input logic pin, input logic signed [SampleW-1:0] v);
    while (!calm && ($urandom_range(99) < 35)) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick       <= t;
    fixed_en   <= pin;
    fixed_val  <= v;
    @(posedge clk);
    while (tick_stall) begin
      @(posedge clk);
    end
    ticks_sent++;
    if (!t) begin
      zero_ticks++;
    end
  endtask

  // Drain: hold off ticks until every sample has been checked.
  task automatic wait_idle();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (samples_checked < ticks_sent) begin
      @(posedge clk);
    end
  endtask

  task automatic write_note(input logic [NoteW-1:0] v);
    note_number_we <= 1'b1;
    note_number    <= v;
    @(posedge clk);
    note_number_we <= 1'b0;
    note_writes++;
  endtask

  initial begin
    logic [NoteW-1:0] nsel;
    build_tables();
    rst            = 1'b1;
    tick_valid     = 1'b0;
    tick           = 1'b0;
    note_number_we = 1'b0;
    note_number    = '0;
    fixed_en       = 1'b0;
    fixed_val      = '0;
    calm           = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DirSteps[i]) begin
      if (DirSteps[i].wr) begin
        wait_idle();
        write_note(DirSteps[i].note);
      end
      send_tick(DirSteps[i].tick, DirSteps[i].pinned, DirSteps[i].val);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      wait_idle();
      case (p)
        0:       nsel = '0;
        1:       nsel = '1;
        2:       nsel = nso_pkg::NoteReset;
        default: nsel = NoteW'($urandom_range(nso_pkg::NoteCount - 1));
      endcase
      write_note(nsel);
      calm <= (p == 5);
      for (int j = 0; j < PhaseItems; j++) begin
        if (p == 7 && j == PhaseItems / 2) begin
          wait_idle();
        end
        send_tick($urandom_range(99) >= 10, 1'b0, '0);
      end
    end

    calm <= 1'b0;
    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_samples.size() != 0) begin
      $display("%0t: %0d samples never arrived", $time, expected_samples.size());
      errors++;
    end
    $display("Ran %0d tick transfers (%0d with tick low) across %0d note writes,",
             ticks_sent, zero_ticks, note_writes);
    $display("notes 0 and 127 included, with random stalls on both sides; %0d samples checked.",
             samples_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
